// ----- rtl/tick_task_scheduler_table_unit_defines.svh -----
// Assertion macros used by the checker file of the scheduler table.
`ifndef TICK_TASK_SCHEDULER_TABLE_UNIT_DEFINES_SVH
`define TICK_TASK_SCHEDULER_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tts_pkg.sv -----
package tts_pkg;

    // Default and largest number of task slots.
    localparam int SLOTS_DEF = 16;
    localparam int SLOTS_MAX = 64;

    // Most results that one dispatch request may give.
    localparam int MAX_OUT = 16;

    // Width of a slot number on the ports and in commands.
    localparam int IDX_W = 6;

    // Width of the dispatch counter, able to hold MAX_OUT itself.
    localparam int CNT_W = $clog2(MAX_OUT + 1);

    typedef enum logic [1:0] {
        OP_TICK,
        OP_ADD,
        OP_DELETE,
        OP_DISPATCH
    } t_op;

    typedef enum logic [2:0] {
        ST_OK,
        ST_FULL,
        ST_BAD_SLOT,
        ST_NONE_READY,
        ST_ZERO_HANDLE
    } t_status;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic             load;     // capture a new request
        logic             exec;     // perform an add or a delete
        logic             rd;       // read one slot for the table walk
        logic [IDX_W-1:0] rd_addr;  // slot read in this cycle
        logic             fin;      // close a tick or an empty dispatch
    } t_cmd;

endpackage

// ----- rtl/tick_task_scheduler_table_unit.sv -----
// Task table of a time-triggered cooperative scheduler. A request is taken when start is
// high and busy is low; each result appears for exactly one cycle with o_strobe high and
// cannot be held off, so the receiver must take it in that cycle. Add and delete give
// their single result after the execute state, with busy high in that state. Tick and
// dispatch walk the table one slot per cycle through the single read port of the slot
// memory, busy high through the walk, drain and finish states: dispatch results appear
// in slot order as the walk reaches each ready slot (at most 16 per request, o_last on
// the final one); a tick or an empty dispatch gives its one result at the end of the walk.
module tick_task_scheduler_table_unit #(
    parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_opcode,
    input  logic [7:0]                i_task_handle,
    input  logic [15:0]               i_first_delay,
    input  logic [15:0]               i_repeat_period,
    input  logic [tts_pkg::IDX_W-1:0] i_slot_index,
    output logic                      o_strobe,
    output logic [2:0]                o_status,
    output logic [tts_pkg::IDX_W-1:0] o_slot,
    output logic [7:0]                o_run_handle,
    output logic                      o_last
);

    tts_pkg::t_cmd cmd;

    // Sequencer for requests and table walks.
    tts_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    // Slot table and result register.
    tts_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_opcode        (i_opcode),
        .i_task_handle   (i_task_handle),
        .i_first_delay   (i_first_delay),
        .i_repeat_period (i_repeat_period),
        .i_slot_index    (i_slot_index),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_run_handle    (o_run_handle),
        .o_last          (o_last)
    );

endmodule

// ----- rtl/tts_ctrl.sv -----
module tts_ctrl #(
    parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_opcode,
    output logic              busy,
    output tts_pkg::t_cmd     o_cmd
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_busy, n_busy;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (tts_pkg::t_op'(i_opcode))
                        tts_pkg::OP_ADD, tts_pkg::OP_DELETE: begin
                            n_state = S_EXEC;
                        end
                        default: begin
                            n_state = S_WALK;
                            n_idx   = '0;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            S_WALK: begin
                o_cmd.rd      = 1'b1;
                o_cmd.rd_addr = tts_pkg::IDX_W'(r_idx);
                if (r_idx == AW'(SLOTS - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    // State, walk index and the registered busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

// ----- rtl/tts_dpath.sv -----
module tts_dpath #(
    parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tts_pkg::t_cmd             i_cmd,
    input  logic [1:0]                i_opcode,
    input  logic [7:0]                i_task_handle,
    input  logic [15:0]               i_first_delay,
    input  logic [15:0]               i_repeat_period,
    input  logic [tts_pkg::IDX_W-1:0] i_slot_index,
    output logic                      o_strobe,
    output logic [2:0]                o_status,
    output logic [tts_pkg::IDX_W-1:0] o_slot,
    output logic [7:0]                o_run_handle,
    output logic                      o_last
);

    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW    = tts_pkg::IDX_W;
    localparam int CW    = tts_pkg::CNT_W;

    typedef struct packed {
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  pending;
        logic [7:0]  handle;
    } t_entry;

    // Captured request.
    tts_pkg::t_op     r_op;
    logic [7:0]       r_handle;
    logic [15:0]      r_delay;
    logic [15:0]      r_period;
    logic [IW-1:0]    r_idx;

    // Slot table memory with a registered read port.
    t_entry           r_mem [SLOTS];
    t_entry           r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_entry           mem_wdata;

    // Occupied and ready flags, one per slot.
    logic [SLOTS-1:0] r_occ, n_occ;
    logic [SLOTS-1:0] r_rdy, n_rdy;

    // Second walk stage: the slot whose data is in r_rdata.
    logic             r_p_valid;
    logic [AW-1:0]    r_p_addr;

    // Results given by the current dispatch.
    logic [CW-1:0]    r_cnt, n_cnt;

    // Result register.
    logic             r_strobe, n_strobe;
    tts_pkg::t_status r_status, n_status;
    logic [IW-1:0]    r_slot, n_slot;
    logic [7:0]       r_run, n_run;
    logic             r_last, n_last;

    logic             free_found;
    logic [AW-1:0]    free_addr;
    logic             ready_above;

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_addr  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                free_found = 1'b1;
                free_addr  = AW'(i);
            end
        end
    end

    // Any ready slot beyond the one being dispatched.
    assign ready_above = |((r_rdy >> r_p_addr) >> 1);

    // Table updates and result selection.
    always_comb begin
        n_occ     = r_occ;
        n_rdy     = r_rdy;
        n_cnt     = r_cnt;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_slot    = r_slot;
        n_run     = r_run;
        n_last    = r_last;
        mem_we    = 1'b0;
        mem_waddr = r_p_addr;
        mem_wdata = r_rdata;

        if (i_cmd.load) begin
            n_cnt = '0;
        end

        // Add or delete, in the cycle after the request is taken.
        if (i_cmd.exec) begin
            n_strobe = 1'b1;
            n_last   = 1'b1;
            n_run    = 8'd0;
            n_slot   = '0;
            if (r_op == tts_pkg::OP_ADD) begin
                if (r_handle == 8'd0) begin
                    n_status = tts_pkg::ST_ZERO_HANDLE;
                end else if (!free_found) begin
                    n_status = tts_pkg::ST_FULL;
                end else begin
                    n_status          = tts_pkg::ST_OK;
                    n_slot            = IW'(free_addr);
                    mem_we            = 1'b1;
                    mem_waddr         = free_addr;
                    mem_wdata.delay   = r_delay;
                    mem_wdata.period  = r_period;
                    mem_wdata.pending = 8'd0;
                    mem_wdata.handle  = r_handle;
                    n_occ[free_addr]  = 1'b1;
                    n_rdy[free_addr]  = 1'b0;
                end
            end else begin
                if ({1'b0, r_idx} >= (IW + 1)'(SLOTS)) begin
                    n_status = tts_pkg::ST_BAD_SLOT;
                end else begin
                    n_status              = tts_pkg::ST_OK;
                    n_slot                = r_idx;
                    n_occ[r_idx[AW-1:0]]  = 1'b0;
                    n_rdy[r_idx[AW-1:0]]  = 1'b0;
                end
            end
        end

        // One slot of a tick or dispatch walk.
        if (r_p_valid && r_occ[r_p_addr]) begin
            if (r_op == tts_pkg::OP_TICK) begin
                mem_we = 1'b1;
                if (r_rdata.delay == 16'd0) begin
                    if (r_rdata.pending != 8'hFF) begin
                        mem_wdata.pending = r_rdata.pending + 8'd1;
                    end
                    n_rdy[r_p_addr] = 1'b1;
                    if (r_rdata.period != 16'd0) begin
                        mem_wdata.delay = r_rdata.period - 16'd1;
                    end
                end else begin
                    mem_wdata.delay = r_rdata.delay - 16'd1;
                end
            end else if (r_rdy[r_p_addr] && (r_cnt != CW'(tts_pkg::MAX_OUT))) begin
                n_strobe = 1'b1;
                n_status = tts_pkg::ST_OK;
                n_slot   = IW'(r_p_addr);
                n_run    = r_rdata.handle;
                n_last   = (r_cnt == CW'(tts_pkg::MAX_OUT - 1)) || !ready_above;
                n_cnt    = r_cnt + CW'(1);
                if (r_rdata.period == 16'd0) begin
                    // One-shot task: free the slot and drop further runs.
                    n_occ[r_p_addr] = 1'b0;
                    n_rdy[r_p_addr] = 1'b0;
                end else begin
                    mem_we            = 1'b1;
                    mem_wdata.pending = r_rdata.pending - 8'd1;
                    n_rdy[r_p_addr]   = (r_rdata.pending != 8'd1);
                end
            end
        end

        // Closing result of a tick, or of a dispatch that found nothing.
        if (i_cmd.fin) begin
            if (r_op == tts_pkg::OP_TICK) begin
                n_strobe = 1'b1;
                n_status = tts_pkg::ST_OK;
                n_slot   = '0;
                n_run    = 8'd0;
                n_last   = 1'b1;
            end else if (r_cnt == '0) begin
                n_strobe = 1'b1;
                n_status = tts_pkg::ST_NONE_READY;
                n_slot   = '0;
                n_run    = 8'd0;
                n_last   = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_rdy     <= '0;
            r_p_valid <= 1'b0;
            r_cnt     <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_occ     <= n_occ;
            r_rdy     <= n_rdy;
            r_p_valid <= i_cmd.rd;
            r_cnt     <= n_cnt;
            r_strobe  <= n_strobe;
        end
    end

    // Request capture, walk address and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= tts_pkg::t_op'(i_opcode);
            r_handle <= i_task_handle;
            r_delay  <= i_first_delay;
            r_period <= i_repeat_period;
            r_idx    <= i_slot_index;
        end
        r_p_addr <= i_cmd.rd_addr[AW-1:0];
        r_status <= n_status;
        r_slot   <= n_slot;
        r_run    <= n_run;
        r_last   <= n_last;
    end

    // Slot table memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_cmd.rd_addr[AW-1:0]];
        end
    end

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_run_handle = r_run;
    assign o_last       = r_last;

endmodule

// ----- rtl/tts_checker.sv -----
`include "tick_task_scheduler_table_unit_defines.svh"

module tts_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_strobe,
    input logic [2:0]                o_status,
    input logic [7:0]                o_run_handle,
    input logic                      o_last
);

    // A taken request always keeps the block busy in the following cycle.
    `TTS_ASSERT_NEXT(a_busy_after_req, start && !busy, busy, "busy not raised after a request")

    // Only a dispatched task can be followed by further results.
    `TTS_ASSERT_SAME(a_mid_is_dispatch, o_strobe && !o_last,
        o_status == tts_pkg::ST_OK && o_run_handle != 8'd0, "non-final result is not a dispatch")

    // Error results always end their request.
    `TTS_ASSERT_SAME(a_error_is_last, o_strobe && o_status != tts_pkg::ST_OK,
        o_last, "error result not marked final")

    // No result directly follows the final result of a request.
    `TTS_ASSERT_NEXT(a_gap_after_last, o_strobe && o_last, !o_strobe,
        "result follows a final result at once")

endmodule

bind tick_task_scheduler_table_unit tts_checker u_tts_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int SLOTS       = tts_pkg::SLOTS_DEF;
    localparam int IW          = tts_pkg::IDX_W;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * SLOTS + 8;
    localparam int MAX_REPORTS = 40;

    // One request waiting to be driven, with the pacing that goes with it.
    typedef struct {
        tts_pkg::t_op     op;
        logic [7:0]       handle;
        logic [15:0]      dly;
        logic [15:0]      per;
        logic [IW-1:0]    idx;
        bit               drain_first;
        int               gap_pct;
    } t_sched_req;

    // One result as the table should report it.
    typedef struct {
        tts_pkg::t_status status;
        logic [IW-1:0]    slot;
        logic [7:0]       run_handle;
        logic             last;
    } t_sched_res;

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             start           = 1'b0;
    logic             busy;
    logic [1:0]       i_opcode        = '0;
    logic [7:0]       i_task_handle   = '0;
    logic [15:0]      i_first_delay   = '0;
    logic [15:0]      i_repeat_period = '0;
    logic [IW-1:0]    i_slot_index    = '0;
    logic             o_strobe;
    logic [2:0]       o_status;
    logic [IW-1:0]    o_slot;
    logic [7:0]       o_run_handle;
    logic             o_last;

    t_sched_req req_queue[$];
    t_sched_res result_exp[$];

    // Shadow copy of the task table.
    logic [7:0]  tbl_handle  [SLOTS];
    logic [15:0] tbl_delay   [SLOTS];
    logic [15:0] tbl_period  [SLOTS];
    logic [7:0]  tbl_pending [SLOTS];

    int errors      = 0;
    int n_checked   = 0;
    int n_runs      = 0;
    int quiet       = 0;
    bit stalled     = 1'b0;
    int op_count[4] = '{0, 0, 0, 0};
    int fill_gap    = 0;
    bit fill_drain  = 1'b0;

    tick_task_scheduler_table_unit #(
        .SLOTS(SLOTS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_task_handle  (i_task_handle),
        .i_first_delay  (i_first_delay),
        .i_repeat_period(i_repeat_period),
        .i_slot_index   (i_slot_index),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_run_handle   (o_run_handle),
        .o_last         (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void push_result(tts_pkg::t_status st, int slot, logic [7:0] hnd,
                                        logic last);
        t_sched_res r;
        r.status     = st;
        r.slot       = slot[IW-1:0];
        r.run_handle = hnd;
        r.last       = last;
        result_exp.push_back(r);
    endfunction

    function automatic void clear_entry(int s);
        tbl_handle[s]  = '0;
        tbl_delay[s]   = '0;
        tbl_period[s]  = '0;
        tbl_pending[s] = '0;
    endfunction

    // Applies one accepted request to the shadow table and queues its results.
    function automatic void schedule_request(tts_pkg::t_op op, logic [7:0] hnd,
                                             logic [15:0] dly, logic [15:0] per,
                                             logic [IW-1:0] idx);
        int s;
        int n;
        int free_s;
        case (op)
            tts_pkg::OP_TICK: begin
                for (s = 0; s < SLOTS; s++) begin
                    if (tbl_handle[s] != 8'd0) begin
                        if (tbl_delay[s] == 16'd0) begin
                            // The pending count sticks at its maximum.
                            if (tbl_pending[s] != 8'hFF)
                                tbl_pending[s] = tbl_pending[s] + 8'd1;
                            if (tbl_period[s] != 16'd0)
                                tbl_delay[s] = tbl_period[s] - 16'd1;
                        end else begin
                            tbl_delay[s] = tbl_delay[s] - 16'd1;
                        end
                    end
                end
                push_result(tts_pkg::ST_OK, 0, 8'd0, 1'b1);
            end
            tts_pkg::OP_ADD: begin
                free_s = -1;
                for (s = SLOTS - 1; s >= 0; s--)
                    if (tbl_handle[s] == 8'd0)
                        free_s = s;
                if (hnd == 8'd0) begin
                    push_result(tts_pkg::ST_ZERO_HANDLE, 0, 8'd0, 1'b1);
                end else if (free_s < 0) begin
                    push_result(tts_pkg::ST_FULL, 0, 8'd0, 1'b1);
                end else begin
                    tbl_handle[free_s]  = hnd;
                    tbl_delay[free_s]   = dly;
                    tbl_period[free_s]  = per;
                    tbl_pending[free_s] = 8'd0;
                    push_result(tts_pkg::ST_OK, free_s, 8'd0, 1'b1);
                end
            end
            tts_pkg::OP_DELETE: begin
                if (int'(idx) >= SLOTS) begin
                    push_result(tts_pkg::ST_BAD_SLOT, 0, 8'd0, 1'b1);
                end else begin
                    clear_entry(int'(idx));
                    push_result(tts_pkg::ST_OK, int'(idx), 8'd0, 1'b1);
                end
            end
            default: begin
                // Ready slots go out in ascending order; one-shot tasks are freed at once.
                n = 0;
                for (s = 0; s < SLOTS && n < tts_pkg::MAX_OUT; s++) begin
                    if (tbl_pending[s] != 8'd0 && tbl_handle[s] != 8'd0) begin
                        push_result(tts_pkg::ST_OK, s, tbl_handle[s], 1'b0);
                        n++;
                        tbl_pending[s] = tbl_pending[s] - 8'd1;
                        if (tbl_period[s] == 16'd0)
                            clear_entry(s);
                    end
                end
                if (n == 0)
                    push_result(tts_pkg::ST_NONE_READY, 0, 8'd0, 1'b1);
                else
                    result_exp[result_exp.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    function automatic void add_req(tts_pkg::t_op op, logic [7:0] hnd, logic [15:0] dly,
                                    logic [15:0] per, logic [IW-1:0] idx);
        t_sched_req q;
        q.op          = op;
        q.handle      = hnd;
        q.dly         = dly;
        q.per         = per;
        q.idx         = idx;
        q.drain_first = fill_drain;
        q.gap_pct     = fill_gap;
        fill_drain    = 1'b0;
        req_queue.push_back(q);
    endfunction

    // Random request: fields unused by the operation carry noise.
    function automatic void add_random_req();
        int            pick;
        tts_pkg::t_op  op;
        logic [7:0]    hnd;
        logic [15:0]   dly;
        logic [15:0]   per;
        logic [IW-1:0] idx;
        pick = int'($urandom_range(99));
        hnd  = 8'($urandom);
        dly  = 16'($urandom);
        per  = 16'($urandom);
        idx  = IW'($urandom);
        if (pick < 30) begin
            op = tts_pkg::OP_TICK;
        end else if (pick < 60) begin
            op  = tts_pkg::OP_ADD;
            hnd = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
            if ($urandom_range(3) != 0)
                dly = 16'($urandom_range(3));
            pick = int'($urandom_range(9));
            if (pick < 3)
                per = '0;
            else if (pick < 8)
                per = 16'($urandom_range(4, 1));
        end else if (pick < 80) begin
            op = tts_pkg::OP_DELETE;
            if ($urandom_range(6) != 0)
                idx = IW'($urandom_range(SLOTS - 1));
            else
                idx = IW'($urandom_range(63, SLOTS));
        end else begin
            op = tts_pkg::OP_DISPATCH;
        end
        add_req(op, hnd, dly, per, idx);
    endfunction

    // Driver: presents the next request and holds it until it is accepted.
    always @(posedge i_clk) begin : driver
        logic       taken;
        logic       go;
        t_sched_req nxt;
        taken = start && !busy;
        go    = 1'b0;
        if (i_rst_n && (!start || taken) && req_queue.size() > 0) begin
            if (req_queue[0].drain_first)
                go = !taken && !o_strobe && !busy && result_exp.size() == 0;
            else
                go = $urandom_range(99) >= req_queue[0].gap_pct;
        end
        if (go) begin
            nxt = req_queue.pop_front();
            start           <= 1'b1;
            i_opcode        <= nxt.op;
            i_task_handle   <= nxt.handle;
            i_first_delay   <= nxt.dly;
            i_repeat_period <= nxt.per;
            i_slot_index    <= nxt.idx;
        end else if (!start || taken) begin
            start <= 1'b0;
        end
    end

    // Monitor: checks each strobed result, then models any request taken at this edge.
    always @(posedge i_clk) begin : monitor
        logic       taken;
        t_sched_res want;
        taken = i_rst_n && start && !busy;
        if (i_rst_n && o_strobe) begin
            if (result_exp.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected status=%0d slot=%0d handle=%0d last=%0d",
                             $time, o_status, o_slot, o_run_handle, o_last);
            end else begin
                want = result_exp.pop_front();
                n_checked++;
                if (want.run_handle != 8'd0)
                    n_runs++;
                if (o_status !== want.status || o_slot !== want.slot ||
                    o_run_handle !== want.run_handle || o_last !== want.last) begin
                    errors++;
                    // Fields are shown as status/slot/handle/last.
                    if (errors <= MAX_REPORTS)
                        $display("%0t: mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                 $time, want.status, want.slot, want.run_handle, want.last,
                                 o_status, o_slot, o_run_handle, o_last);
                end
            end
        end
        if (taken) begin
            schedule_request(tts_pkg::t_op'(i_opcode), i_task_handle, i_first_delay,
                             i_repeat_period, i_slot_index);
            op_count[i_opcode]++;
        end
        // Watchdog on cycles where neither a request nor a result moves.
        if (taken || (i_rst_n && o_strobe))
            quiet = 0;
        else if (i_rst_n)
            quiet++;
        if (quiet >= STALL_LIMIT)
            stalled = 1'b1;
    end

    initial begin : stimulus
        int s;
        int k;
        for (s = 0; s < SLOTS; s++)
            clear_entry(s);

        // Directed part: empty table, rejected requests, a full table and a full dispatch.
        fill_gap = 8;
        add_req(tts_pkg::OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom), IW'($urandom));
        add_req(tts_pkg::OP_DISPATCH, 8'($urandom), 16'($urandom), 16'($urandom),
                IW'($urandom));
        add_req(tts_pkg::OP_ADD, 8'd0, 16'd5, 16'd5, 6'd0);
        add_req(tts_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 6'(SLOTS));
        add_req(tts_pkg::OP_DELETE, 8'hFF, 16'hFFFF, 16'hFFFF, 6'd63);
        add_req(tts_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 6'd5);
        add_req(tts_pkg::OP_ADD, 8'hFF, 16'd0, 16'd0, 6'd0);
        add_req(tts_pkg::OP_ADD, 8'h01, 16'd0, 16'hFFFF, 6'd0);
        for (s = 2; s < SLOTS; s++)
            add_req(tts_pkg::OP_ADD, 8'(s * 17), 16'd0, 16'(s % 3), 6'd0);
        add_req(tts_pkg::OP_ADD, 8'h77, 16'd1, 16'd1, 6'd0);
        // Two ticks leave each one-shot task with two runs due.
        add_req(tts_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 6'd0);
        add_req(tts_pkg::OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F);
        add_req(tts_pkg::OP_DISPATCH, 8'd0, 16'd0, 16'd0, 6'd0);
        add_req(tts_pkg::OP_DISPATCH, 8'd0, 16'd0, 16'd0, 6'd0);
        add_req(tts_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 6'd1);
        add_req(tts_pkg::OP_ADD, 8'h01, 16'hFFFF, 16'hFFFF, 6'd0);

        // Random part in three pacing phases, each opened once the table has gone quiet.
        fill_gap   = 8;
        fill_drain = 1'b1;
        for (k = 0; k < 57; k++)
            add_random_req();
        fill_gap   = 62;
        fill_drain = 1'b1;
        for (k = 0; k < 57; k++)
            add_random_req();
        fill_gap   = 0;
        fill_drain = 1'b1;
        for (k = 0; k < 57; k++)
            add_random_req();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!stalled && (req_queue.size() != 0 || start || result_exp.size() != 0))
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (result_exp.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, result_exp.size());
            errors += result_exp.size();
        end
        if (stalled)
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Ran %0d ticks, %0d adds, %0d deletes and %0d dispatches.",
                 op_count[tts_pkg::OP_TICK], op_count[tts_pkg::OP_ADD],
                 op_count[tts_pkg::OP_DELETE], op_count[tts_pkg::OP_DISPATCH]);
        $display("Checked %0d results, %0d of them task runs.", n_checked, n_runs);
        if (!stalled && errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
